/* design/lta_pkg.sv */
// lta_pkg: shared types, register indexes and constants for lora time on air
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lta_pkg;

  // channel and register port widths
  localparam int LenW     = 8;
  localparam int OutW     = 22;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_SF       = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_BW       = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_CR       = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_CRC      = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_PREAMBLE = 3'd4;

  // legal spreading factor and bandwidth code limits
  localparam logic [3:0] SF_MIN   = 4'd6;
  localparam logic [3:0] SF_MAX   = 4'd12;
  localparam logic [1:0] BW_MAX   = 2'd2;
  localparam logic [1:0] BW_125K  = 2'd0;
  localparam logic [3:0] SF_DE_LO = 4'd11;

  // block count divider: floor(y / d) = (y * ceil(2^16 / d)) >> 16, exact for y < 1024
  localparam int RecipW     = 14;
  localparam int RecipShift = 16;

  // ms divider: floor(w / 125) = (w * ceil(2^36 / 125)) >> 36, exact for w < 2^29
  localparam int               MsMulW   = 30;
  localparam logic [MsMulW-1:0] MS_RECIP = 30'd549755814;
  localparam int               MsShift  = 36;

  // settings after saturation, as the datapath uses them
  typedef struct packed {
    logic [3:0]        sf;        // saturated spreading factor, 6..12
    logic [3:0]        sym_div;   // sf minus twice the low rate flag, 6..12
    logic [RecipW-1:0] recip;     // ceil(2^16 / sym_div)
    logic [3:0]        cr_fac;    // coding rate plus four
    logic              crc;
    logic [15:0]       preamble;
    logic [3:0]        shift;     // sf minus bandwidth code, 4..12
  } lta_cfg_t;

  // reciprocal table for the block count divider
  function automatic logic [RecipW-1:0] recip_of(input logic [3:0] d);
    logic [RecipW-1:0] r;
    unique case (d)
      4'd6:    r = 14'd10923;
      4'd7:    r = 14'd9363;
      4'd8:    r = 14'd8192;
      4'd9:    r = 14'd7282;
      4'd10:   r = 14'd6554;
      4'd11:   r = 14'd5958;
      4'd12:   r = 14'd5462;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/lta_cfg.sv */
// lta_cfg: radio setting registers and the values derived from them
// depends on lta_pkg
`timescale 1ns / 1ps

module lta_cfg
  import lta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output lta_cfg_t            cfg_o
);

  logic [3:0]  sf_r;
  logic [1:0]  bw_r;
  logic [2:0]  cr_r;
  logic        crc_r;
  logic [15:0] pre_r;

  logic [3:0]  sf_sat;
  logic [1:0]  bw_sat;
  logic        de;
  logic [3:0]  sym_div;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r  <= 4'd7;
      bw_r  <= 2'd0;
      cr_r  <= 3'd1;
      crc_r <= 1'b1;
      pre_r <= 16'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SF:       sf_r  <= cfg_wdata[3:0];
        REG_BW:       bw_r  <= cfg_wdata[1:0];
        REG_CR:       cr_r  <= cfg_wdata[2:0];
        REG_CRC:      crc_r <= cfg_wdata[0];
        REG_PREAMBLE: pre_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // saturate settings, low data rate optimisation flag
  always_comb begin
    if (sf_r < SF_MIN)      sf_sat = SF_MIN;
    else if (sf_r > SF_MAX) sf_sat = SF_MAX;
    else                    sf_sat = sf_r;
    bw_sat  = (bw_r > BW_MAX) ? BW_MAX : bw_r;
    de      = (sf_sat >= SF_DE_LO) && (bw_sat == BW_125K);
    sym_div = de ? (sf_sat - 4'd2) : sf_sat;
  end

  assign cfg_o.sf       = sf_sat;
  assign cfg_o.sym_div  = sym_div;
  assign cfg_o.recip    = recip_of(sym_div);
  assign cfg_o.cr_fac   = {1'b0, cr_r} + 4'd4;
  assign cfg_o.crc      = crc_r;
  assign cfg_o.preamble = pre_r;
  assign cfg_o.shift    = sf_sat - {2'b00, bw_sat};

endmodule

/* design/lta_sym.sv */
// lta_sym: three stage pipe from payload length to four times the packet symbol count
// depends on lta_pkg
`timescale 1ns / 1ps

module lta_sym
  import lta_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [LenW-1:0] len,
  input  lta_cfg_t        cfg,
  output logic            sym_valid,
  output logic [18:0]     sym4
);

  logic        v1_r, v2_r, v3_r;
  logic [9:0]  y_r, y_nxt;
  logic [6:0]  blk_r, blk_nxt;
  logic [18:0] sym4_r, sym4_nxt;

  logic [11:0] t;
  logic [11:0] s4;
  logic [11:0] x;
  logic [23:0] prod;
  logic [10:0] blk_syms;
  logic [9:0]  psyms;

  // stage 1: ceiling numerator, quartered, zero when not positive
  always_comb begin
    t     = {1'b0, len, 3'b000} + 12'd28 + (cfg.crc ? 12'd16 : 12'd0);
    s4    = {6'd0, cfg.sf, 2'b00};
    x     = t - s4 + {6'd0, cfg.sym_div, 2'b00} - 12'd1;
    y_nxt = (t > s4) ? x[11:2] : 10'd0;
  end

  // stage 2: block count by reciprocal multiply
  always_comb begin
    prod    = {14'd0, y_r} * {10'd0, cfg.recip};
    blk_nxt = prod[RecipShift+6:RecipShift];
  end

  // stage 3: payload symbols and quarter-symbol total
  always_comb begin
    blk_syms = {4'd0, blk_r} * {7'd0, cfg.cr_fac};
    psyms    = blk_syms[9:0] + 10'd8;
    sym4_nxt = {1'b0, cfg.preamble, 2'b00} + 19'd17 + {7'd0, psyms, 2'b00};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      y_r    <= y_nxt;
      blk_r  <= blk_nxt;
      sym4_r <= sym4_nxt;
    end
  end

  assign sym_valid = v3_r;
  assign sym4      = sym4_r;

endmodule

/* design/lta_scale.sv */
// lta_scale: two stage pipe from quarter-symbol total to milliseconds, rounded up
// depends on lta_pkg
`timescale 1ns / 1ps

module lta_scale
  import lta_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            sym_valid,
  input  logic [18:0]     sym4,
  input  logic [3:0]      shift,
  output logic            ms_valid,
  output logic [OutW-1:0] ms
);

  logic            v4_r, v5_r;
  logic [28:0]     w_r, w_nxt;
  logic [OutW-1:0] ms_r, ms_nxt;

  logic [30:0] q;
  logic [31:0] z;
  logic [58:0] prod;

  // stage 4: scale to 125 kHz chips, ms = floor((2q + 999) / 1000)
  always_comb begin
    q     = {12'd0, sym4} << shift;
    z     = {q, 1'b0} + 32'd999;
    w_nxt = z[31:3];
  end

  // stage 5: divide by 125 through reciprocal multiply
  always_comb begin
    prod   = {30'd0, w_r} * {29'd0, MS_RECIP};
    ms_nxt = prod[MsShift+OutW-1:MsShift];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sym_valid;
      v5_r <= v4_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      w_r  <= w_nxt;
      ms_r <= ms_nxt;
    end
  end

  assign ms_valid = v5_r;
  assign ms       = ms_r;

endmodule

/* design/lora_time_on_air.sv */
// lora_time_on_air: top level, time on air of a lora packet in milliseconds
// depends on lta_pkg, lta_cfg, lta_sym, lta_scale
//
//   channel   | direction | content
//   in_       | slave     | payload length, one word per packet
//   out_      | master    | time on air in ms, one word per input word
//   cfg_      | write     | radio settings, indexes 0..4
//
// five register stages; a word can enter every cycle unless out_ stalls; its result
// passes through y, blk, sym4 and w and is shown in the output register ms
// at most one multiplier per stage sets depth (block count, symbols, ms divide)
// a stall on the out_ side freezes all stages at once, nothing lost or repeated
// synchronous active low reset clears valid bits and restores default settings
`timescale 1ns / 1ps

module lora_time_on_air
  import lta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,    // [7:0] payload_length
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,   // [21:0] airtime_ms, [23:22] zero
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  lta_cfg_t        cfg;
  logic            adv;
  logic            sym_valid;
  logic [18:0]     sym4;
  logic            ms_valid;
  logic [OutW-1:0] ms;

  // pipe moves whenever the output register is free or being taken
  assign adv       = !ms_valid || out_tready;
  assign in_tready = adv;

  // settings
  lta_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // symbol count stages
  lta_sym u_sym (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .len       (in_tdata[LenW-1:0]),
    .cfg       (cfg),
    .sym_valid (sym_valid),
    .sym4      (sym4)
  );

  // time scaling stages
  lta_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sym_valid (sym_valid),
    .sym4      (sym4),
    .shift     (cfg.shift),
    .ms_valid  (ms_valid),
    .ms        (ms)
  );

  assign out_tvalid = ms_valid;
  assign out_tdata  = {2'b00, ms};

endmodule
